// ===== rtl/ehc_pkg.sv =====
package ehc_pkg;

  localparam int unsigned MAX_BINS    = 256;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned BIN_W       = $clog2(MAX_BINS);
  localparam int unsigned NB_W        = BIN_W + 1;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned PROD_W      = SAMPLE_BITS + NB_W;
  localparam int unsigned ITER_W      = $clog2(BIN_W);
  localparam int unsigned QDEPTH      = 2;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DROP = 2'd1,
    ST_SAT  = 2'd2,
    ST_BAD  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_LOW   = 2'd0,
    REG_HIGH  = 2'd1,
    REG_NBINS = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_READ   = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_DROP   = 3'd3,
    OP_BAD    = 3'd4,
    OP_NOP    = 3'd5
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] bin;
  } entry_t;

endpackage

// ===== rtl/ehc_ram.sv =====
module ehc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ehc_front.sv =====
module ehc_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [1:0]                             action_i,
  input  logic signed [ehc_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic [ehc_pkg::IDX_W-1:0]              read_bin_i,
  input  logic signed [ehc_pkg::SAMPLE_BITS-1:0] range_low_i,
  input  logic signed [ehc_pkg::SAMPLE_BITS-1:0] range_high_i,
  input  logic [ehc_pkg::NB_W-1:0]               nbins_i,
  input  logic                                   full_i,
  output logic                                   busy_o,
  output logic                                   push_o,
  output ehc_pkg::entry_t                        entry_o
);

  localparam int unsigned SB = ehc_pkg::SAMPLE_BITS;
  localparam int unsigned BW = ehc_pkg::BIN_W;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_CALC = 5'b00010,
    F_PREP = 5'b00100,
    F_DIV  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_e;

  fstate_e                            state_q, state_d;
  ehc_pkg::action_e                   act_q, act_d;
  logic signed [SB-1:0]               sample_q, sample_d;
  logic [ehc_pkg::IDX_W-1:0]          rbin_q, rbin_d;
  logic [ehc_pkg::PROD_W-1:0]         prod_q, prod_d;
  logic [SB-1:0]                      span_q, span_d;
  logic [SB-1:0]                      rem_q, rem_d;
  logic [BW-1:0]                      numlo_q, numlo_d;
  logic [BW-1:0]                      quot_q, quot_d;
  logic [ehc_pkg::ITER_W-1:0]         iter_q, iter_d;
  ehc_pkg::entry_t                    entry_q, entry_d;

  logic signed [SB:0]                 x_ext, lo_ext, hi_ext, d_full, span_full;
  logic [SB-1:0]                      d_val;
  logic                               drop;
  logic [ehc_pkg::PROD_W-1:0]         num;
  logic [SB:0]                        trial, trial_sub;
  logic                               ge;
  logic [BW-1:0]                      q_next;

  always_comb begin
    x_ext     = {sample_q[SB-1], sample_q};
    lo_ext    = {range_low_i[SB-1], range_low_i};
    hi_ext    = {range_high_i[SB-1], range_high_i};
    d_full    = x_ext - lo_ext;
    span_full = hi_ext - lo_ext;
    d_val     = d_full[SB-1:0];
    drop      = (range_high_i <= range_low_i) || (sample_q < range_low_i)
             || (sample_q > range_high_i);
    num       = prod_q - ehc_pkg::PROD_W'(1);
    trial     = {rem_q, numlo_q[BW-1]};
    trial_sub = trial - {1'b0, span_q};
    ge        = trial >= {1'b0, span_q};
    q_next    = {quot_q[BW-2:0], ge};
  end

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    sample_d = sample_q;
    rbin_d   = rbin_q;
    prod_d   = prod_q;
    span_d   = span_q;
    rem_d    = rem_q;
    numlo_d  = numlo_q;
    quot_d   = quot_q;
    iter_d   = iter_q;
    entry_d  = entry_q;
    unique case (state_q)
      F_IDLE: begin
        if (start_i) begin
          act_d    = ehc_pkg::action_e'(action_i);
          sample_d = sample_i;
          rbin_d   = read_bin_i;
          state_d  = F_CALC;
        end
      end
      F_CALC: begin
        span_d  = span_full[SB-1:0];
        prod_d  = ehc_pkg::PROD_W'(d_val) * ehc_pkg::PROD_W'(nbins_i);
        state_d = F_PUSH;
        unique case (act_q)
          ehc_pkg::ACT_INSERT: begin
            if (drop) begin
              entry_d = '{op: ehc_pkg::OP_DROP, bin: '0};
            end else if (d_val == '0) begin
              entry_d = '{op: ehc_pkg::OP_INSERT, bin: '0};
            end else begin
              state_d = F_PREP;
            end
          end
          ehc_pkg::ACT_CLEAR: begin
            entry_d = '{op: ehc_pkg::OP_CLEAR, bin: '0};
          end
          ehc_pkg::ACT_READ: begin
            if (ehc_pkg::NB_W'(rbin_q) >= nbins_i) begin
              entry_d = '{op: ehc_pkg::OP_BAD, bin: rbin_q};
            end else begin
              entry_d = '{op: ehc_pkg::OP_READ, bin: rbin_q};
            end
          end
          default: begin
            entry_d = '{op: ehc_pkg::OP_NOP, bin: '0};
          end
        endcase
      end
      F_PREP: begin
        rem_d   = num[BW+SB-1:BW];
        numlo_d = num[BW-1:0];
        quot_d  = '0;
        iter_d  = '0;
        state_d = F_DIV;
      end
      F_DIV: begin
        rem_d   = ge ? trial_sub[SB-1:0] : trial[SB-1:0];
        numlo_d = {numlo_q[BW-2:0], 1'b0};
        quot_d  = q_next;
        iter_d  = iter_q + ehc_pkg::ITER_W'(1);
        if (iter_q == ehc_pkg::ITER_W'(BW - 1)) begin
          entry_d = '{op: ehc_pkg::OP_INSERT, bin: ehc_pkg::IDX_W'(q_next)};
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    sample_q <= sample_d;
    rbin_q   <= rbin_d;
    prod_q   <= prod_d;
    span_q   <= span_d;
    rem_q    <= rem_d;
    numlo_q  <= numlo_d;
    quot_q   <= quot_d;
    entry_q  <= entry_d;
  end

  assign busy_o  = (state_q != F_IDLE);
  assign push_o  = (state_q == F_PUSH) && !full_i;
  assign entry_o = entry_q;

endmodule

// ===== rtl/ehc_queue.sv =====
module ehc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ehc_pkg::entry_t entry_i,
  input  logic            pop_i,
  output ehc_pkg::entry_t head_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned PTR_W = (ehc_pkg::QDEPTH > 1) ? $clog2(ehc_pkg::QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(ehc_pkg::QDEPTH + 1);

  ehc_pkg::entry_t  slot_q [ehc_pkg::QDEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] fill_q, fill_d;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(ehc_pkg::QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wptr_d = push_i ? bump(wptr_q) : wptr_q;
    rptr_d = pop_i ? bump(rptr_q) : rptr_q;
    fill_d = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= entry_i;
    end
  end

  assign head_o  = slot_q[rptr_q];
  assign empty_o = (fill_q == '0);
  assign full_o  = (fill_q == CNT_W'(ehc_pkg::QDEPTH));

endmodule

// ===== rtl/ehc_back.sv =====
module ehc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_all_i,
  input  logic                       empty_i,
  input  ehc_pkg::entry_t            head_i,
  output logic                       pop_o,
  output logic                       done_o,
  output logic [ehc_pkg::IDX_W-1:0]  bin_index_o,
  output logic [ehc_pkg::CNT_W-1:0]  count_o,
  output logic [1:0]                 status_o
);

  localparam int unsigned BW = ehc_pkg::BIN_W;
  localparam int unsigned CW = ehc_pkg::CNT_W;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_WAIT = 2'b10
  } bstate_e;

  bstate_e                    state_q, state_d;
  ehc_pkg::entry_t            cur_q, cur_d;
  logic [ehc_pkg::MAX_BINS-1:0] valid_q, valid_d;
  logic                       done_q, done_d;
  logic [ehc_pkg::IDX_W-1:0]  bin_q, bin_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  ehc_pkg::status_e           st_q, st_d;

  logic                       we;
  logic [CW-1:0]              wdata, rdata, cur_cnt;

  assign pop_o = (state_q == B_IDLE) && !empty_i;

  ehc_ram #(
    .WIDTH(CW),
    .DEPTH(ehc_pkg::MAX_BINS)
  ) u_counts (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cur_q.bin[BW-1:0]),
    .wdata_i(wdata),
    .re_i   (pop_o),
    .raddr_i(head_i.bin[BW-1:0]),
    .rdata_o(rdata)
  );

  assign cur_cnt = valid_q[cur_q.bin[BW-1:0]] ? rdata : '0;
  assign wdata   = cur_cnt + CW'(1);

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    valid_d = valid_q;
    done_d  = 1'b0;
    bin_d   = bin_q;
    cnt_d   = cnt_q;
    st_d    = st_q;
    we      = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (pop_o) begin
          cur_d = head_i;
          bin_d = '0;
          cnt_d = '0;
          st_d  = ehc_pkg::ST_OK;
          unique case (head_i.op)
            ehc_pkg::OP_INSERT, ehc_pkg::OP_READ: begin
              state_d = B_WAIT;
            end
            ehc_pkg::OP_CLEAR: begin
              valid_d = '0;
              done_d  = 1'b1;
            end
            ehc_pkg::OP_DROP: begin
              st_d   = ehc_pkg::ST_DROP;
              done_d = 1'b1;
            end
            ehc_pkg::OP_BAD: begin
              bin_d  = head_i.bin;
              st_d   = ehc_pkg::ST_BAD;
              done_d = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      B_WAIT: begin
        done_d  = 1'b1;
        bin_d   = cur_q.bin;
        state_d = B_IDLE;
        if (cur_q.op == ehc_pkg::OP_READ) begin
          cnt_d = cur_cnt;
          st_d  = ehc_pkg::ST_OK;
        end else if (&cur_cnt) begin
          cnt_d = cur_cnt;
          st_d  = ehc_pkg::ST_SAT;
        end else begin
          we                         = 1'b1;
          valid_d[cur_q.bin[BW-1:0]] = 1'b1;
          cnt_d                      = wdata;
          st_d                       = ehc_pkg::ST_OK;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
    if (clear_all_i) begin
      valid_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    bin_q <= bin_d;
    cnt_q <= cnt_d;
    st_q  <= st_d;
  end

  assign done_o      = done_q;
  assign bin_index_o = bin_q;
  assign count_o     = cnt_q;
  assign status_o    = st_q;

endmodule

// ===== rtl/equal_width_histogram_counter.sv =====
// An insert that needs a bin search takes the longest path from the accepting edge to the
// result strobe; every other beat bypasses the divider in the front end.
// A new beat is taken only once the front end is idle; an insert with a bin search first
// runs the 8-step restoring divider, and a push into a full queue stalls the front end.
// Results are strobed for one cycle and cannot be stalled. Reset restores the register
// defaults and empties every bin at once through per-bin valid bits, with no sweep.
module equal_width_histogram_counter (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             action_i,
  input  logic signed [ehc_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic [ehc_pkg::IDX_W-1:0]              read_bin_i,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [3:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  output logic                                   done_o,
  output logic [ehc_pkg::IDX_W-1:0]              bin_index_o,
  output logic [ehc_pkg::CNT_W-1:0]              count_o,
  output logic [1:0]                             status_o
);

  localparam int unsigned SB = ehc_pkg::SAMPLE_BITS;
  localparam int unsigned NB = ehc_pkg::NB_W;

  logic signed [SB-1:0] low_q, high_q;
  logic [8:0]           nbins_q;
  logic [NB-1:0]        nbins_use;
  logic                 cfg_we, cfg_clear;
  ehc_pkg::reg_e        cfg_idx;

  logic                 push, pop, empty, full;
  ehc_pkg::entry_t      entry, head;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = ehc_pkg::reg_e'(paddr[3:2]);

  always_comb begin
    cfg_clear = 1'b0;
    prdata    = '0;
    unique case (cfg_idx)
      ehc_pkg::REG_LOW: begin
        cfg_clear = cfg_we;
        prdata    = {16'd0, low_q};
      end
      ehc_pkg::REG_HIGH: begin
        cfg_clear = cfg_we;
        prdata    = {16'd0, high_q};
      end
      ehc_pkg::REG_NBINS: begin
        cfg_clear = cfg_we;
        prdata    = {23'd0, nbins_q};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q   <= '0;
      high_q  <= 16'sd32767;
      nbins_q <= 9'd16;
    end else if (cfg_we) begin
      if (cfg_idx == ehc_pkg::REG_LOW) begin
        low_q <= pwdata[15:0];
      end
      if (cfg_idx == ehc_pkg::REG_HIGH) begin
        high_q <= pwdata[15:0];
      end
      if (cfg_idx == ehc_pkg::REG_NBINS) begin
        nbins_q <= pwdata[8:0];
      end
    end
  end

  always_comb begin
    if (nbins_q == '0) begin
      nbins_use = NB'(1);
    end else if (32'(nbins_q) > ehc_pkg::MAX_BINS) begin
      nbins_use = NB'(ehc_pkg::MAX_BINS);
    end else begin
      nbins_use = NB'(nbins_q);
    end
  end

  ehc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .action_i    (action_i),
    .sample_i    (sample_i),
    .read_bin_i  (read_bin_i),
    .range_low_i (low_q),
    .range_high_i(high_q),
    .nbins_i     (nbins_use),
    .full_i      (full),
    .busy_o      (busy),
    .push_o      (push),
    .entry_o     (entry)
  );

  ehc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(empty),
    .full_o (full)
  );

  ehc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_all_i(cfg_clear),
    .empty_i    (empty),
    .head_i     (head),
    .pop_o      (pop),
    .done_o     (done_o),
    .bin_index_o(bin_index_o),
    .count_o    (count_o),
    .status_o   (status_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("front end did not go busy after taking a beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ehc_pkg::ST_SAT) |-> (&count_o))
    else $error("saturated result without a full count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ehc_pkg::ST_DROP) |-> (count_o == '0 && bin_index_o == '0))
    else $error("dropped sample reported a bin or count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ehc_pkg::ST_BAD) |-> (NB'(bin_index_o) >= nbins_use))
    else $error("bad bin reported for a bin in use");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import ehc_pkg::*;

  localparam int N_DIR          = 22;
  localparam int N_PHASES       = 11;
  localparam int N_FIXED_PHASES = 8;
  localparam int BEATS_PER_PHASE = 135;
  localparam int CYCLE_LIMIT    = 500000;

  typedef struct packed {
    logic [IDX_W-1:0] bin;
    logic [CNT_W-1:0] cnt;
    status_e          st;
  } beat_t;

  typedef struct {
    action_e                       act;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic [IDX_W-1:0]              rbin;
    bit                            typed;
    logic [IDX_W-1:0]              e_bin;
    logic [CNT_W-1:0]              e_cnt;
    status_e                       e_st;
  } dir_row_t;

  typedef struct {
    int lo;
    int hi;
    int nb;
  } range_cfg_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [1:0]                    action_i = 2'd0;
  logic signed [SAMPLE_BITS-1:0] sample_i = '0;
  logic [IDX_W-1:0]              read_bin_i = '0;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [3:0]                    paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          done_o;
  logic [IDX_W-1:0]              bin_index_o;
  logic [CNT_W-1:0]              count_o;
  logic [1:0]                    status_o;

  equal_width_histogram_counter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (action_i),
    .sample_i    (sample_i),
    .read_bin_i  (read_bin_i),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .done_o      (done_o),
    .bin_index_o (bin_index_o),
    .count_o     (count_o),
    .status_o    (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int          range_lo = 0;
  int          range_hi = 32767;
  int unsigned bins_raw = 16;
  logic [CNT_W-1:0] tally [MAX_BINS];
  beat_t       owed_beats [$];
  beat_t       head_beat;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          idle_on = 1'b1;

  dir_row_t dir_rows [N_DIR] = '{
    '{ACT_READ,   16'sd0,     8'd0,   1'b1, 8'd0,   32'd0, ST_OK},
    '{ACT_READ,   16'sd0,     8'd15,  1'b1, 8'd15,  32'd0, ST_OK},
    '{ACT_READ,   16'sd0,     8'd16,  1'b1, 8'd16,  32'd0, ST_BAD},
    '{ACT_READ,   16'sd0,     8'd255, 1'b1, 8'd255, 32'd0, ST_BAD},
    '{ACT_INSERT, 16'sd0,     8'd0,   1'b1, 8'd0,   32'd1, ST_OK},
    '{ACT_INSERT, 16'sh7FFF,  8'd0,   1'b1, 8'd15,  32'd1, ST_OK},
    '{ACT_INSERT, -16'sd1,    8'd0,   1'b1, 8'd0,   32'd0, ST_DROP},
    '{ACT_INSERT, 16'sh8000,  8'd0,   1'b1, 8'd0,   32'd0, ST_DROP},
    '{ACT_INSERT, 16'sd1,     8'd0,   1'b0, 8'd0,   32'd0, ST_OK},
    '{ACT_INSERT, 16'sd2047,  8'd0,   1'b0, 8'd0,   32'd0, ST_OK},
    '{ACT_INSERT, 16'sd2048,  8'd0,   1'b0, 8'd0,   32'd0, ST_OK},
    '{ACT_INSERT, 16'sd16384, 8'd0,   1'b0, 8'd0,   32'd0, ST_OK},
    '{ACT_INSERT, 16'sd32766, 8'd0,   1'b0, 8'd0,   32'd0, ST_OK},
    '{ACT_NONE,   16'sh1234,  8'd7,   1'b1, 8'd0,   32'd0, ST_OK},
    '{ACT_READ,   16'sd0,     8'd0,   1'b0, 8'd0,   32'd0, ST_OK},
    '{ACT_READ,   16'sd0,     8'd1,   1'b0, 8'd0,   32'd0, ST_OK},
    '{ACT_CLEAR,  16'sd0,     8'd0,   1'b1, 8'd0,   32'd0, ST_OK},
    '{ACT_READ,   16'sd0,     8'd0,   1'b1, 8'd0,   32'd0, ST_OK},
    '{ACT_READ,   16'sd0,     8'd15,  1'b1, 8'd15,  32'd0, ST_OK},
    '{ACT_INSERT, 16'sd30000, 8'd0,   1'b0, 8'd0,   32'd0, ST_OK},
    '{ACT_NONE,   -16'sd1,    8'd255, 1'b1, 8'd0,   32'd0, ST_OK},
    '{ACT_READ,   16'sd0,     8'd14,  1'b0, 8'd0,   32'd0, ST_OK}
  };

  range_cfg_t fixed_cfgs [N_FIXED_PHASES] = '{
    '{-32768, 32767, 256},
    '{0,      1,     1},
    '{-100,   100,   0},
    '{-5,     5,     511},
    '{1000,   1000,  7},
    '{32767,  -32768, 3},
    '{-32768, -32767, 2},
    '{32766,  32767, 256}
  };

  function automatic int bins_now();
    if (bins_raw < 1) return 1;
    if (bins_raw > MAX_BINS) return MAX_BINS;
    return bins_raw;
  endfunction

  function automatic void clear_tally();
    foreach (tally[k]) tally[k] = '0;
  endfunction

  function automatic beat_t predict_histogram(action_e act, logic signed [SAMPLE_BITS-1:0] smp,
                                              logic [IDX_W-1:0] rbin);
    beat_t  r;
    longint n;
    longint x;
    longint span;
    longint d;
    longint i;
    r = '{bin: '0, cnt: '0, st: ST_OK};
    n = bins_now();
    case (act)
      ACT_INSERT: begin
        x = smp;
        if (range_hi <= range_lo || x < range_lo || x > range_hi) begin
          r.st = ST_DROP;
        end else begin
          span = range_hi - range_lo;
          d = x - range_lo;
          i = (d == 0) ? 0 : (d * n + span - 1) / span - 1;
          if (i >= n) i = n - 1;
          if (tally[i] == '1) r.st = ST_SAT;
          else tally[i] = tally[i] + 1;
          r.bin = i[IDX_W-1:0];
          r.cnt = tally[i];
        end
      end
      ACT_CLEAR: clear_tally();
      ACT_READ: begin
        r.bin = rbin;
        if (rbin >= n) r.st = ST_BAD;
        else r.cnt = tally[rbin];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    longint n;
    longint span;
    longint k;
    longint v;
    n = bins_now();
    span = range_hi - range_lo;
    case ($urandom_range(0, 9))
      0: v = range_lo;
      1: v = range_hi;
      2: v = range_lo - 1;
      3: v = range_hi + 1;
      4, 5, 6: begin
        if (span > 0) begin
          k = $urandom_range(0, n);
          v = range_lo + (k * span) / n + longint'($urandom_range(0, 2)) - 1;
        end else begin
          v = $urandom;
        end
      end
      7: v = (span > 0) ? range_lo + longint'($urandom_range(0, span)) : $urandom;
      default: v = $urandom;
    endcase
    return v[SAMPLE_BITS-1:0];
  endfunction

  task automatic send_beat(action_e act, logic signed [SAMPLE_BITS-1:0] smp,
                           logic [IDX_W-1:0] rbin, bit typed, beat_t typed_beat);
    beat_t p;
    start      <= 1'b1;
    action_i   <= act;
    sample_i   <= smp;
    read_bin_i <= rbin;
    do @(posedge clk_i); while (busy);
    p = predict_histogram(act, smp, rbin);
    owed_beats.push_back(typed ? typed_beat : p);
  endtask

  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic random_beat();
    int      pick;
    action_e act;
    logic [IDX_W-1:0] rbin;
    pick = $urandom_range(0, 99);
    if (pick < 60) act = ACT_INSERT;
    else if (pick < 90) act = ACT_READ;
    else if (pick < 95) act = ACT_CLEAR;
    else act = ACT_NONE;
    if ($urandom_range(0, 1) == 0) rbin = IDX_W'($urandom_range(0, 255));
    else rbin = IDX_W'($urandom_range(0, bins_now() - 1));
    send_beat(act, pick_sample(), rbin, 1'b0, '0);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (owed_beats.size() != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_LOW:  range_lo = int'(signed'(value[15:0]));
      REG_HIGH: range_hi = int'(signed'(value[15:0]));
      default:  bins_raw = value[8:0];
    endcase
    clear_tally();
  endtask

  task automatic load_config(range_cfg_t c);
    write_reg(REG_LOW,   {16'h0, 16'(c.lo)});
    write_reg(REG_HIGH,  {16'h0, 16'(c.hi)});
    write_reg(REG_NBINS, {23'h0, 9'(c.nb)});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (owed_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: bin %0d count %0d status %0d",
                   bin_index_o, count_o, status_o);
      end else begin
        head_beat = owed_beats.pop_front();
        if (bin_index_o !== head_beat.bin || count_o !== head_beat.cnt ||
            status_o !== head_beat.st) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected bin %0d count %0d status %0d, got %0d %0d %0d",
                     head_beat.bin, head_beat.cnt, head_beat.st,
                     bin_index_o, count_o, status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    range_cfg_t c;
    beat_t      typed_beat;
    clear_tally();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The directed rows run on the register values left by reset.
    foreach (dir_rows[r]) begin
      typed_beat = '{bin: dir_rows[r].e_bin, cnt: dir_rows[r].e_cnt, st: dir_rows[r].e_st};
      send_beat(dir_rows[r].act, dir_rows[r].smp, dir_rows[r].rbin, dir_rows[r].typed,
                typed_beat);
      maybe_idle();
    end
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph < N_FIXED_PHASES) begin
        c = fixed_cfgs[ph];
      end else begin
        c.lo = int'($urandom_range(0, 65535)) - 32768;
        c.hi = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                           : c.lo + int'($urandom_range(1, 32767 - c.lo));
        c.nb = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 20) : $urandom_range(0, 511);
      end
      load_config(c);
      for (int b = 0; b < BEATS_PER_PHASE; b++) begin
        if (b % 40 == 0) idle_on = (ph != N_PHASES - 1) && ($urandom_range(0, 2) != 0);
        random_beat();
        // Hold off once until every outstanding beat has come back.
        if (ph == 0 && b == 60) begin
          start <= 1'b0;
          while (owed_beats.size() != 0) @(posedge clk_i);
        end else begin
          maybe_idle();
        end
      end
      drain();
    end

    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0 && owed_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
